[rtl/core/calorimeter_energy_threshold_defines.svh]
`ifndef CALORIMETER_ENERGY_THRESHOLD_DEFINES_SVH
`define CALORIMETER_ENERGY_THRESHOLD_DEFINES_SVH

// same-cycle implication on the block clock, off while in reset
`define CET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the block clock, off while in reset
`define CET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cet_pkg.sv]
package cet_pkg;

    // detector geometry and calibration scaling
    localparam int GAIN_PER_LEU   = 1024;
    localparam int LOGS_PER_LAYER = 12;
    localparam int TOWERS         = 16;
    localparam int RANGES         = 4;
    localparam int LAYERS         = 8;

    // energy scale divide is a shift: the gain scale is a power of two
    localparam int LEU_SHIFT = $clog2(GAIN_PER_LEU);

    // one calibration bank per log end, each indexed by tower/layer/column/range
    localparam int CAL_BANK_DEPTH = TOWERS * LAYERS * LOGS_PER_LAYER * RANGES;
    localparam int CAL_AW         = $clog2(CAL_BANK_DEPTH);

    // queue sizes
    localparam int OPQ_DEPTH  = 4;
    localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    // request command codes
    localparam logic [1:0] CMD_LOG = 2'd0;
    localparam logic [1:0] CMD_EOE = 2'd1;
    localparam logic [1:0] CMD_CAL = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_LOG,
        OP_EOE,
        OP_CAL
    } t_op_kind;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  tower;
        logic [2:0]  layer;
        logic [3:0]  column;
        logic [1:0]  range_a;
        logic [1:0]  range_b;
        logic [11:0] adc_a;
        logic [11:0] adc_b;
        logic        check_point;
        logic        cal_end;
        logic [11:0] cal_pedestal;
        logic [15:0] cal_gain;
    } t_item;

    typedef struct packed {
        logic signed [31:0] excess;
        logic               passed;
    } t_result;

    typedef struct packed {
        t_op_kind          kind;
        logic [CAL_AW-1:0] addr_a;
        logic [CAL_AW-1:0] addr_b;
        logic              ok_a;
        logic              ok_b;
        logic [11:0]       adc_a;
        logic [11:0]       adc_b;
        logic              check_point;
        logic              cal_end;
        logic [27:0]       cal_data;
    } t_op;

    // bank address of one log end
    function automatic logic [CAL_AW-1:0] cal_addr(
        input logic [3:0] tower,
        input logic [2:0] layer,
        input logic [3:0] column,
        input logic [1:0] rng
    );
        int a;
        a = ((int'(tower) * LAYERS + int'(layer)) * LOGS_PER_LAYER + int'(column))
            * RANGES + int'(rng);
        return CAL_AW'(a);
    endfunction

    // entry exists in the calibration memory
    function automatic logic cal_ok(
        input logic [3:0] tower,
        input logic [3:0] column,
        input logic [1:0] rng
    );
        return (int'(tower) < TOWERS) && (int'(column) < LOGS_PER_LAYER)
            && (int'(rng) < RANGES);
    endfunction

endpackage

[rtl/core/cet_front.sv]
module cet_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cet_pkg::t_item i_item,
    output logic          o_full,
    output logic          o_op_v,
    output cet_pkg::t_op  o_op,
    input  logic          i_op_full
);
    import cet_pkg::*;

    logic r_v;
    t_op  r_op;
    logic n_v;
    t_op  n_op;
    logic w_take;
    logic w_known;

    assign o_full = r_v && i_op_full;
    assign w_take = i_push && !o_full;
    assign o_op_v = r_v;
    assign o_op   = r_op;

    // classify the request and work out both calibration addresses
    always_comb begin
        n_op             = r_op;
        w_known          = 1'b1;
        n_op.kind        = OP_LOG;
        n_op.addr_a      = cal_addr(i_item.tower, i_item.layer, i_item.column, i_item.range_a);
        n_op.addr_b      = cal_addr(i_item.tower, i_item.layer, i_item.column, i_item.range_b);
        n_op.ok_a        = cal_ok(i_item.tower, i_item.column, i_item.range_a);
        n_op.ok_b        = cal_ok(i_item.tower, i_item.column, i_item.range_b);
        n_op.adc_a       = i_item.adc_a;
        n_op.adc_b       = i_item.adc_b;
        n_op.check_point = i_item.check_point;
        n_op.cal_end     = i_item.cal_end;
        n_op.cal_data    = {i_item.cal_gain, i_item.cal_pedestal};
        case (i_item.cmd)
            CMD_LOG: n_op.kind = OP_LOG;
            CMD_EOE: n_op.kind = OP_EOE;
            CMD_CAL: n_op.kind = OP_CAL;
            default: w_known = 1'b0;
        endcase
    end

    // stage holds until the queue takes it; unknown commands are dropped here
    always_comb begin
        if (w_take) begin
            n_v = w_known;
        end else begin
            n_v = r_v && i_op_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op <= n_op;
        end
    end

endmodule

[rtl/core/cet_op_queue.sv]
module cet_op_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  cet_pkg::t_op i_data,
    output logic         o_full,
    output logic         o_empty,
    output cet_pkg::t_op o_data,
    input  logic         i_pop
);
    import cet_pkg::*;

    t_op               r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wr;
    logic [OPQ_AW-1:0] r_rd;
    logic [OPQ_AW:0]   r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == (OPQ_AW + 1)'(OPQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/cet_back.sv]
module cet_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_op_empty,
    input  cet_pkg::t_op                  i_op,
    output logic                          o_op_pop,
    input  logic                          i_cfg_we,
    input  logic [23:0]                   i_cfg_wdata,
    input  logic [cet_pkg::RESQ_CW-1:0]   i_res_cnt,
    output logic                          o_res_push,
    output cet_pkg::t_result              o_res
);
    import cet_pkg::*;

    // calibration banks, one per log end: {gain, pedestal}
    logic [27:0] r_cal_a [CAL_BANK_DEPTH];
    logic [27:0] r_cal_b [CAL_BANK_DEPTH];
    logic [27:0] r_rd_a;
    logic [27:0] r_rd_b;

    // stage 1: calibration read
    logic        r_s1_v;
    t_op_kind    r_s1_kind;
    logic        r_s1_ok_a;
    logic        r_s1_ok_b;
    logic [11:0] r_s1_adc_a;
    logic [11:0] r_s1_adc_b;
    logic        r_s1_check;

    // stage 2: products, then accumulate
    logic               r_s2_v;
    t_op_kind           r_s2_kind;
    logic               r_s2_check;
    logic signed [29:0] r_prod_a;
    logic signed [29:0] r_prod_b;

    // event state
    logic [23:0] r_thresh;
    logic [31:0] r_sum;
    logic        r_decided;
    logic [23:0] n_thresh;
    logic [31:0] n_sum;
    logic        n_decided;

    logic [RESQ_CW:0]   w_inflight;
    logic               w_issue;
    logic [11:0]        w_ped_a;
    logic [11:0]        w_ped_b;
    logic signed [16:0] w_gain_a;
    logic signed [16:0] w_gain_b;
    logic signed [12:0] w_diff_a;
    logic signed [12:0] w_diff_b;
    logic signed [29:0] w_prod_a;
    logic signed [29:0] w_prod_b;
    logic signed [29:0] w_q_a;
    logic signed [29:0] w_q_b;
    logic signed [30:0] w_e;
    logic signed [30:0] w_half;
    logic [31:0]        w_sum_new;
    logic               w_hit;

    // quotient by the gain scale, truncated toward zero
    function automatic logic signed [29:0] leu_div(input logic signed [29:0] p);
        logic signed [29:0] adj;
        adj = p + $signed(30'(GAIN_PER_LEU - 1));
        return (p < 0) ? (adj >>> LEU_SHIFT) : (p >>> LEU_SHIFT);
    endfunction

    // issue only with room reserved in the result queue for everything in flight
    assign w_inflight = {1'b0, i_res_cnt} + (RESQ_CW + 1)'(r_s1_v) + (RESQ_CW + 1)'(r_s2_v);
    assign w_issue    = !i_op_empty && (int'(w_inflight) < RESQ_DEPTH);
    assign o_op_pop   = w_issue;

    // bank a: calibration write or read
    always_ff @(posedge i_clk) begin
        if (w_issue && i_op.kind == OP_CAL && i_op.ok_a && !i_op.cal_end) begin
            r_cal_a[i_op.addr_a] <= i_op.cal_data;
        end
        r_rd_a <= r_cal_a[i_op.addr_a];
    end

    // bank b: writes use the request range, reads use end b's range
    always_ff @(posedge i_clk) begin
        if (w_issue && i_op.kind == OP_CAL && i_op.ok_a && i_op.cal_end) begin
            r_cal_b[i_op.addr_a] <= i_op.cal_data;
        end
        r_rd_b <= r_cal_b[i_op.addr_b];
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        r_s1_kind  <= i_op.kind;
        r_s1_ok_a  <= i_op.ok_a;
        r_s1_ok_b  <= i_op.ok_b;
        r_s1_adc_a <= i_op.adc_a;
        r_s1_adc_b <= i_op.adc_b;
        r_s1_check <= i_op.check_point;
    end

    // per-end pedestal subtract and gain multiply; missing entries give zero
    always_comb begin
        w_ped_a  = r_s1_ok_a ? r_rd_a[11:0] : '0;
        w_ped_b  = r_s1_ok_b ? r_rd_b[11:0] : '0;
        w_gain_a = r_s1_ok_a ? $signed({1'b0, r_rd_a[27:12]}) : '0;
        w_gain_b = r_s1_ok_b ? $signed({1'b0, r_rd_b[27:12]}) : '0;
        w_diff_a = $signed({1'b0, r_s1_adc_a}) - $signed({1'b0, w_ped_a});
        w_diff_b = $signed({1'b0, r_s1_adc_b}) - $signed({1'b0, w_ped_b});
        w_prod_a = 30'(w_diff_a) * 30'(w_gain_a);
        w_prod_b = 30'(w_diff_b) * 30'(w_gain_b);
    end

    always_ff @(posedge i_clk) begin
        r_s2_kind  <= r_s1_kind;
        r_s2_check <= r_s1_check;
        r_prod_a   <= w_prod_a;
        r_prod_b   <= w_prod_b;
    end

    // scale, combine the two ends, floor-halve and accumulate
    always_comb begin
        w_q_a     = leu_div(r_prod_a);
        w_q_b     = leu_div(r_prod_b);
        w_e       = 31'(w_q_a) + 31'(w_q_b);
        w_half    = w_e >>> 1;
        w_sum_new = r_sum + {w_half[30], w_half};
        w_hit     = r_s2_check && !w_sum_new[31];
    end

    // event state update
    always_comb begin
        n_thresh  = r_thresh;
        n_sum     = r_sum;
        n_decided = r_decided;
        if (i_cfg_we) begin
            n_thresh  = i_cfg_wdata;
            n_sum     = 32'd0 - {8'd0, i_cfg_wdata};
            n_decided = 1'b0;
        end else if (r_s2_v) begin
            case (r_s2_kind)
                OP_EOE: begin
                    n_sum     = 32'd0 - {8'd0, r_thresh};
                    n_decided = 1'b0;
                end
                OP_LOG: begin
                    if (!r_decided) begin
                        n_sum     = w_sum_new;
                        n_decided = w_hit;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= '0;
            r_sum     <= '0;
            r_decided <= 1'b0;
        end else begin
            r_thresh  <= n_thresh;
            r_sum     <= n_sum;
            r_decided <= n_decided;
        end
    end

    // result request towards the output queue
    always_comb begin
        o_res_push = 1'b0;
        o_res      = '0;
        if (r_s2_v && !r_decided) begin
            case (r_s2_kind)
                OP_EOE: begin
                    o_res_push = 1'b1;
                    o_res      = '{excess: $signed(r_sum), passed: !r_sum[31]};
                end
                OP_LOG: begin
                    o_res_push = w_hit;
                    o_res      = '{excess: $signed(w_sum_new), passed: 1'b1};
                end
                default: ;
            endcase
        end
    end

endmodule

[rtl/core/cet_res_queue.sv]
module cet_res_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  cet_pkg::t_result            i_data,
    output logic [cet_pkg::RESQ_CW-1:0] o_cnt,
    output logic                        o_empty,
    output cet_pkg::t_result            o_data,
    input  logic                        i_pop
);
    import cet_pkg::*;

    t_result            r_mem [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wr;
    logic [RESQ_AW-1:0] r_rd;
    logic [RESQ_CW-1:0] r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_cnt   = r_cnt;
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    // space is reserved upstream before issue
    assign w_push  = i_push && (r_cnt != RESQ_CW'(RESQ_DEPTH));
    assign w_pop   = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/calorimeter_energy_threshold.sv]
// path: a log or end-of-event request passes the front register, op queue, calibration read,
//   multiply and accumulate before any result it yields reaches the result queue
// throughput: one request per cycle, set by one read port per calibration bank
//   and one multiplier per log end; stalls when waiting results plus requests in flight
//   would overfill the result queue
// reset: synchronous active low; clears queues, threshold and sum to zero;
//   the calibration memory is not cleared and must be written before it is read
module calorimeter_energy_threshold (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  cet_pkg::t_item   i_item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output cet_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [23:0]      i_cfg_wdata
);
    import cet_pkg::*;

    logic               w_op_v;
    t_op                w_op_in;
    logic               w_op_full;
    logic               w_op_empty;
    t_op                w_op_out;
    logic               w_op_pop;
    logic [RESQ_CW-1:0] w_res_cnt;
    logic               w_res_push;
    t_result            w_res;

    // request classification
    cet_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_op_v    (w_op_v),
        .o_op      (w_op_in),
        .i_op_full (w_op_full)
    );

    // decoupling queue
    cet_op_queue u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_v),
        .i_data  (w_op_in),
        .o_full  (w_op_full),
        .o_empty (w_op_empty),
        .o_data  (w_op_out),
        .i_pop   (w_op_pop)
    );

    // calibration, energy and decision
    cet_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_empty  (w_op_empty),
        .i_op        (w_op_out),
        .o_op_pop    (w_op_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_res_cnt   (w_res_cnt),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // result queue
    cet_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_cnt   (w_res_cnt),
        .o_empty (empty),
        .o_data  (o_result),
        .i_pop   (pop)
    );

endmodule

[rtl/core/cet_checker.sv]
`include "calorimeter_energy_threshold_defines.svh"

module cet_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input cet_pkg::t_result o_result
);
    import cet_pkg::*;

    // pass flag follows the sign of the excess
    `CET_ASSERT_NOW(a_passed_sign, !empty, o_result.passed == !o_result.excess[31], "pass flag")

    // a waiting result holds until popped
    `CET_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(o_result), "result moved")

    // input side only fills after an accepted request
    `CET_ASSERT_NOW(a_full_rise, $rose(full), $past(push) && !$past(full), "full without push")

endmodule

bind calorimeter_energy_threshold cet_checker u_cet_checker (.*);
